@@ hw/rtl/tal_pkg.sv @@
// Package for the tree ancestor lift table.
// Holds parameter defaults, operation codes, register addresses and field widths.
// Depends on nothing.
`default_nettype none

package tal_pkg;

	// Default table geometry.
	localparam int MAX_NODES_DEF = 1024;
	localparam int LEVELS_DEF    = 11;

	// Item field widths.
	localparam int NODE_W  = 10;
	localparam int STEPS_W = 10;

	// Operation codes carried in s_tuser.
	localparam logic OP_ATTACH = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Configuration register map (byte addresses).
	localparam int          PADDR_W       = 2;
	localparam logic [1:0]  REG_LEVELS    = 2'd0;
	localparam logic [3:0]  LEVELS_RESET  = 4'd10;

endpackage

`default_nettype wire

@@ hw/rtl/tree_ancestor_lift_table_top.sv @@
// Top level of the tree ancestor lift table: row memory, sequencer and APB register.
// Depends on tal_pkg.
//
// Usage:
// Items enter on the s_ stream. s_tuser selects attach or query; s_tdata carries
// the node, the parent (attach) and the step count (query). Every item yields
// exactly one result item on the m_ stream: the ancestor index in m_tdata and
// the found flag in m_tuser.
// The table keeps one row per node with one entry per lifting level, held in a
// single-port-read, single-port-write memory whose read data is registered. All
// work goes through that one read port under a small sequencer, so rate is set
// by the number of dependent row reads.
// Attach: one dependent row read per higher level filled, until the fill stops at
// an absent level or passes the top level in use; then the row is written back.
// Query: one step per level walked, with a row read for each set step bit.
// Every item passes through a done state before the sequencer returns to idle.
// s_tready is high only while the sequencer is idle; one finished result may
// wait in the output register while the next item is accepted and worked on.
// If the receiver stalls, the sequencer holds its next result until the output
// register frees up.
// After reset the block runs a clearing pass (one row per cycle) with s_tready
// low; APB writes are taken throughout.
// The user must write levels_in_use only while the block is idle; the block does not enforce it.
`default_nettype none

module tree_ancestor_lift_table_top
	import tal_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int LEVELS    = LEVELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input stream.
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,   // [9:0] node, [19:10] parent_node, [29:20] steps
	input  wire logic               s_tuser,   // [0] operation
	// Result stream.
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,   // [9:0] ancestor
	output logic                    m_tuser,   // [0] found
	// Configuration port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LMAX  = (LEVELS > STEPS_W) ? LEVELS : STEPS_W;
	localparam int CW    = $clog2(LMAX + 1);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ARD   = 3'd2;
	localparam logic [2:0] S_AWAIT = 3'd3;
	localparam logic [2:0] S_AWR   = 3'd4;
	localparam logic [2:0] S_QSTEP = 3'd5;
	localparam logic [2:0] S_QWAIT = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	typedef logic [LEVELS-1:0][AW:0] row_t;

	// Row memory and its ports.
	row_t              mem [MAX_NODES];
	row_t              rd_row_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	row_t              wr_row;

	// Control and working registers.
	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [3:0]        levels_cfg_q;
	logic [CW-1:0]     h_q;
	logic [CW-1:0]     lvl_q;
	logic [CW-1:0]     lvl_m1;
	logic [LIW-1:0]    lvl_idx;
	logic [LIW-1:0]    lvl_m1_idx;
	logic [AW-1:0]     node_q;
	logic [NODE_W-1:0] par_q;
	logic [STEPS_W-1:0] steps_q;
	logic [AW-1:0]     cur_q;
	row_t              row_q;
	logic              byp_q;
	logic [NODE_W-1:0] res_anc_q;
	logic              res_found_q;
	logic              m_tvalid_q;
	logic [NODE_W-1:0] m_anc_q;
	logic              m_found_q;

	// Input item fields.
	logic              s_op;
	logic [NODE_W-1:0] s_node;
	logic [NODE_W-1:0] s_par;
	logic [STEPS_W-1:0] s_steps;
	logic              node_ok;
	logic              par_ok;
	logic [CW-1:0]     h_eff;
	logic [AW:0]       prev_ent;
	logic [AW:0]       fill_ent;
	logic [AW:0]       walk_ent;
	logic              cfg_wr;

	assign s_op    = s_tuser;
	assign s_node  = s_tdata[9:0];
	assign s_par   = s_tdata[19:10];
	assign s_steps = s_tdata[29:20];

	assign node_ok = 32'(s_node) < 32'(MAX_NODES);
	assign par_ok  = 32'(s_par) < 32'(MAX_NODES);

	// Effective top level, capped at the table's highest level.
	always_comb begin
		if (32'(levels_cfg_q) > 32'(LEVELS - 1)) begin
			h_eff = CW'(LEVELS - 1);
		end else begin
			h_eff = CW'(levels_cfg_q);
		end
	end

	// Level index helpers.
	assign lvl_m1     = lvl_q - 1'b1;
	assign lvl_idx    = lvl_q[LIW-1:0];
	assign lvl_m1_idx = lvl_m1[LIW-1:0];

	// Entries looked at by the attach fill and the query walk.
	assign prev_ent = row_q[lvl_m1_idx];
	assign fill_ent = byp_q ? row_q[lvl_m1_idx] : rd_row_q[lvl_m1_idx];
	assign walk_ent = rd_row_q[lvl_idx];

	// Memory read address: the ancestor row for attach, the current node for query.
	always_comb begin
		case (state_q)
			S_ARD:   rd_addr = prev_ent[AW-1:0];
			S_QSTEP: rd_addr = cur_q;
			default: rd_addr = cur_q;
		endcase
	end

	// Memory write: clearing pass or the finished row of an attach.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_row  = row_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_row  = '0;
			end
			S_AWR: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Row memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		rd_row_q <= mem[rd_addr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			lvl_q       <= '0;
			h_q         <= '0;
			byp_q       <= 1'b0;
			res_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						node_q  <= AW'(s_node);
						par_q   <= s_par;
						steps_q <= s_steps;
						h_q     <= h_eff;
						cur_q   <= AW'(s_node);
						if (s_op == OP_ATTACH) begin
							res_anc_q <= s_par;
							if (node_ok && par_ok) begin
								// New row: the parent at level 0, every higher level absent.
								row_q   <= {{((LEVELS - 1) * (AW + 1)){1'b0}}, 1'b1, AW'(s_par)};
								lvl_q   <= CW'(1);
								state_q <= S_ARD;
							end else begin
								res_found_q <= 1'b0;
								state_q     <= S_DONE;
							end
						end else begin
							if (node_ok) begin
								lvl_q   <= '0;
								state_q <= S_QSTEP;
							end else begin
								res_anc_q   <= '0;
								res_found_q <= 1'b0;
								state_q     <= S_DONE;
							end
						end
					end
				end
				// Fetch the row of the ancestor one level down.
				S_ARD: begin
					if (32'(lvl_q) >= 32'(LEVELS) || lvl_q > h_q) begin
						state_q <= S_AWR;
					end else begin
						byp_q   <= (prev_ent[AW-1:0] == node_q);
						state_q <= S_AWAIT;
					end
				end
				// Take the doubled ancestor, or stop at the first absent level.
				S_AWAIT: begin
					if (fill_ent[AW]) begin
						row_q[lvl_idx] <= fill_ent;
						lvl_q          <= lvl_q + 1'b1;
						state_q        <= S_ARD;
					end else begin
						state_q <= S_AWR;
					end
				end
				S_AWR: begin
					res_anc_q   <= par_q;
					res_found_q <= 1'b1;
					state_q     <= S_DONE;
				end
				// Walk the step bits one level at a time.
				S_QSTEP: begin
					if (lvl_q > h_q || 32'(lvl_q) >= STEPS_W) begin
						res_anc_q   <= NODE_W'(cur_q);
						res_found_q <= 1'b1;
						state_q     <= S_DONE;
					end else if (steps_q[lvl_q[$clog2(STEPS_W)-1:0]]) begin
						state_q <= S_QWAIT;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_QWAIT: begin
					if (walk_ent[AW]) begin
						cur_q   <= walk_ent[AW-1:0];
						lvl_q   <= lvl_q + 1'b1;
						state_q <= S_QSTEP;
					end else begin
						res_anc_q   <= '0;
						res_found_q <= 1'b0;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loaded from the sequencer's result when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_anc_q   <= res_anc_q;
			m_found_q <= res_found_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - NODE_W){1'b0}}, m_anc_q};
	assign m_tuser  = m_found_q;

	// Configuration register.
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_cfg_q <= LEVELS_RESET;
		end else if (cfg_wr && paddr == REG_LEVELS) begin
			levels_cfg_q <= pwdata[3:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_LEVELS) ? {28'd0, levels_cfg_q} : 32'd0;

endmodule

`default_nettype wire

@@ bench/lift_table_checker.sv @@
// Checker for the tree ancestor lift table: watches the item streams and the APB port,
// predicts each result from its own copy of the ancestor table and compares.
// Depends on tal_pkg.
`default_nettype none

module lift_table_checker
	import tal_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [31:0]        s_tdata,   // [9:0] node, [19:10] parent_node, [29:20] steps
	input  wire logic               s_tuser,   // [0] operation
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [15:0]        m_tdata,   // [9:0] ancestor
	input  wire logic               m_tuser,   // [0] found
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic [31:0]        prdata,
	input  wire logic               pready,
	output int                      mismatches,
	output int                      awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor;
		logic              found;
	} answer_t;

	// Each entry is a valid bit over a node index.
	logic [NODE_W:0]   lift_store [MAX_NODES_DEF][LEVELS_DEF];
	logic [3:0]        levels_reg;
	answer_t           awaited_answers [$];
	int                fail_tally;

	// Applies one item to the table copy and returns the result it must produce.
	function automatic answer_t lift_predict(input logic op, input logic [NODE_W-1:0] node,
		input logic [NODE_W-1:0] parent, input logic [STEPS_W-1:0] steps);
		answer_t           res;
		int                top_lvl;
		logic              alive;
		logic [NODE_W:0]   prev;
		logic [NODE_W:0]   v;
		logic [NODE_W-1:0] cur;
		top_lvl = (levels_reg > LEVELS_DEF - 1) ? LEVELS_DEF - 1 : int'(levels_reg);
		if (op == OP_ATTACH) begin
			lift_store[node][0] = {1'b1, parent};
			alive = 1'b1;
			for (int i = 1; i < LEVELS_DEF; i++) begin
				v = '0;
				if (alive && i <= top_lvl) begin
					prev = lift_store[node][i-1];
					if (prev[NODE_W])
						v = lift_store[prev[NODE_W-1:0]][i-1];
					if (!v[NODE_W]) begin
						v = '0;
						alive = 1'b0;
					end
				end
				lift_store[node][i] = v;
			end
			res.ancestor = parent;
			res.found = 1'b1;
		end else begin
			// Climb one power of two for each set step bit within the levels in use.
			cur = node;
			res.found = 1'b1;
			for (int i = 0; i <= top_lvl && i < STEPS_W; i++) begin
				if (steps[i] && res.found) begin
					v = lift_store[cur][i];
					if (!v[NODE_W])
						res.found = 1'b0;
					else
						cur = v[NODE_W-1:0];
				end
			end
			res.ancestor = res.found ? cur : '0;
		end
		return res;
	endfunction

	// Track register accesses, predict accepted items and compare accepted results.
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			for (int n = 0; n < MAX_NODES_DEF; n++)
				for (int l = 0; l < LEVELS_DEF; l++)
					lift_store[n][l] = '0;
			levels_reg = LEVELS_RESET;
			awaited_answers.delete();
			fail_tally = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (psel && penable && pready && paddr == REG_LEVELS) begin
				if (pwrite) begin
					levels_reg = pwdata[3:0];
				end else if (prdata[3:0] !== levels_reg) begin
					$error("levels_in_use: expected %0d, got %0d", levels_reg, prdata[3:0]);
					fail_tally++;
				end
			end
			if (s_tvalid && s_tready)
				awaited_answers.insert(awaited_answers.size(),
					lift_predict(s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[29:20]));
			if (m_tvalid && m_tready) begin
				if (awaited_answers.size() == 0) begin
					$error("result item with no expectation: ancestor %0d, found %0d",
						m_tdata[9:0], m_tuser);
					fail_tally++;
				end else begin
					want = awaited_answers.pop_front();
					if (m_tdata[9:0] !== want.ancestor) begin
						$error("ancestor: expected %0d, got %0d", want.ancestor, m_tdata[9:0]);
						fail_tally++;
					end
					if (m_tuser !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, m_tuser);
						fail_tally++;
					end
				end
			end
			mismatches <= fail_tally;
			awaited <= awaited_answers.size();
		end
	end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Top of the tree ancestor lift table bench: clock, reset, stimulus and verdict.
// Builds trees through attach items, walks them with query items, and relies on
// lift_table_checker for all prediction; depends on tal_pkg and the block's RTL.
`default_nettype none

module testbench;
	import tal_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_WAIT  = 30;
	localparam int PHASE_ITEMS  = 153;
	localparam int PHASES       = 8;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;   // [9:0] node, [19:10] parent_node, [29:20] steps
	logic               s_tuser;   // [0] operation
	logic               m_tvalid;
	logic               m_tready;
	logic [15:0]        m_tdata;   // [9:0] ancestor
	logic               m_tuser;   // [0] found
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatches;
	int                 awaited;

	int                 sender_idle_pct;
	int                 receiver_stall_pct;
	int                 hold_seq;
	int                 quiet_cycles;

	// Shape of the trees built so far, used only to aim the stimulus.
	logic               attached [MAX_NODES_DEF];
	int                 depth_of [MAX_NODES_DEF];
	int                 attached_list [$];
	int                 fresh_node;
	int                 tip_node;
	int                 deepest_node;

	tree_ancestor_lift_table_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lift_table_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mismatches(mismatches), .awaited(awaited)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one item, with random idle cycles ahead of it, and waits for its acceptance.
	task automatic offer_item(input logic op, input logic [31:0] word);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic attach_item(input int node, input int parent);
		offer_item(OP_ATTACH, {2'b0, 10'($urandom), 10'(parent), 10'(node)});
		depth_of[node] = attached[parent] ? depth_of[parent] + 1 : 1;
		if (depth_of[node] > 1023)
			depth_of[node] = 1023;
		if (!attached[node])
			attached_list.insert(attached_list.size(), node);
		attached[node] = 1'b1;
		tip_node = node;
		if (depth_of[node] > depth_of[deepest_node])
			deepest_node = node;
	endtask

	task automatic query_item(input int node, input int steps);
		offer_item(OP_QUERY, {2'b0, 10'(steps), 10'($urandom), 10'(node)});
	endtask

	// Writes levels_in_use and reads it back.
	task automatic set_levels(input logic [3:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_LEVELS;
		pwdata <= {28'b0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly grows chains under recent or deep nodes; some items are noise.
	task automatic random_item();
		int pick;
		int node;
		int parent;
		int steps;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			node = ($urandom_range(0, 99) < 75) ? fresh_node : $urandom_range(0, 1023);
			fresh_node = (fresh_node + 1) % MAX_NODES_DEF;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				parent = tip_node;
			else if (pick < 65)
				parent = deepest_node;
			else if (pick < 88)
				parent = attached_list[$urandom_range(0, attached_list.size() - 1)];
			else
				parent = $urandom_range(0, 1023);
			attach_item(node, parent);
		end else begin
			if ($urandom_range(0, 99) < 85)
				node = attached_list[$urandom_range(0, attached_list.size() - 1)];
			else
				node = $urandom_range(0, 1023);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				steps = $urandom_range(0, (depth_of[node] + 1 > 1023) ? 1023 : depth_of[node] + 1);
			else if (pick < 80)
				steps = 1 << $urandom_range(0, 9);
			else
				steps = $urandom_range(0, 1023);
			query_item(node, steps);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_seen;
		hold_seen = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog on cycles in which nothing is accepted anywhere.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [3:0] level_plan [PHASES];
		level_plan = '{4'd10, 4'd0, 4'd3, 4'd15, 4'd11, 4'd1, 4'd7, 4'd10};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ATTACH;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_seq = 0;
		fresh_node = 6;
		tip_node = 0;
		deepest_node = 0;
		for (int n = 0; n < MAX_NODES_DEF; n++) begin
			attached[n] = 1'b0;
			depth_of[n] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			// Let the block drain before touching the register.
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (awaited != 0) @(posedge clk);
			repeat (SETTLE_WAIT) @(posedge clk);
			set_levels(level_plan[p]);
			sender_idle_pct = (p % 4 == 1) ? 57 : (p % 4 == 3) ? 14 : 0;
			receiver_stall_pct = (p % 4 == 2) ? 57 : (p % 4 == 3) ? 14 : 0;

			if (p == 0) begin
				// Zero steps on a lone node, and a walk off an empty table.
				query_item(0, 0);
				query_item(1023, 1);
				// A chain hanging under a node that was never attached.
				attach_item(1, 0);
				attach_item(2, 1);
				attach_item(3, 2);
				attach_item(4, 3);
				attach_item(5, 4);
				query_item(5, 4);
				query_item(5, 5);
				query_item(5, 6);
				query_item(5, 1023);
				// A self-parented node at the top index, then the chain put under it.
				attach_item(1023, 1023);
				query_item(1023, 1023);
				attach_item(0, 1023);
				query_item(5, 5);
				query_item(5, 6);
				// Re-attach moves a node and must clear its old higher levels.
				attach_item(3, 0);
				query_item(3, 2);
				query_item(3, 3);
				attach_item(512, 5);
				query_item(512, 512);
				// Long hold-off on the result side while items keep coming.
				hold_seq = hold_seq + 1;
			end

			for (int k = 0; k < PHASE_ITEMS; k++)
				random_item();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
